[rtl/core/uule_pkg.sv]
// Shared constants, types and helper functions of the uuencode line encoder.
package uule_pkg;

    localparam int LINE_BYTES  = 45;
    localparam int LINE_GROUPS = LINE_BYTES / 3;
    localparam int GRP_IDX_W   = (LINE_GROUPS > 1) ? $clog2(LINE_GROUPS) : 1;
    localparam int GRP_CNT_W   = $clog2(LINE_GROUPS + 2);
    localparam int CNT_W       = $clog2(LINE_BYTES + 1);
    localparam int CHAR_W      = 7;
    localparam int OUT_DATA_W  = 32;

    localparam logic [CHAR_W-1:0] SEQ_HIGH   = 7'd122;
    localparam logic [CHAR_W-1:0] SEQ_LOW    = 7'd97;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'd32;
    localparam logic [CHAR_W-1:0] CHAR_NL    = 7'd10;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'd0;

    localparam logic [2:0] COUNT_LEN   = 3'd1;
    localparam logic [2:0] COUNT_CLOSE = 3'd2;
    localparam logic [2:0] COUNT_TERM  = 3'd3;
    localparam logic [2:0] COUNT_GROUP = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_READ,
        ST_GROUP,
        ST_CLOSE,
        ST_TERM
    } state_t;

    typedef enum logic [2:0] {
        LD_NONE,
        LD_LEN,
        LD_GRP,
        LD_CLOSE,
        LD_TERM
    } load_t;

    typedef struct packed {
        logic  store;
        logic  rd_issue;
        load_t load;
        logic  last;
    } cmd_t;

    typedef struct packed {
        logic buf_empty;
        logic fills_line;
        logic more_groups;
        logic out_free;
    } status_t;

    // Maps a 6-bit value onto the printable range starting at space.
    function automatic logic [CHAR_W-1:0] enc6(input logic [5:0] v);
        return {1'b0, v} + CHAR_SPACE;
    endfunction

    // Sequence character counts down from 'z' to 'a', then wraps.
    function automatic logic [CHAR_W-1:0] next_seq(input logic [CHAR_W-1:0] s);
        logic [CHAR_W-1:0] r;
        if (s <= SEQ_LOW || s > SEQ_HIGH)
        begin
            r = SEQ_HIGH;
        end
        else
        begin
            r = s - 7'd1;
        end
        return r;
    endfunction

endpackage

[rtl/core/uule_ctrl.sv]
// Control state machine of the uuencode line encoder.
module uule_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             mode,
    input  uule_pkg::status_t sts,
    output logic             s_tready,
    output uule_pkg::cmd_t   cmd
);
    import uule_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   end_reg;
    logic   end_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            end_reg   <= end_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        end_next     = end_reg;
        s_tready     = 1'b0;
        cmd.store    = 1'b0;
        cmd.rd_issue = 1'b0;
        cmd.load     = LD_NONE;
        cmd.last     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (mode)
                    begin
                        end_next   = 1'b1;
                        state_next = sts.buf_empty ? ST_TERM : ST_LEN;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                        if (sts.fills_line)
                        begin
                            end_next   = 1'b0;
                            state_next = ST_LEN;
                        end
                    end
                end
            end
            ST_LEN:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = LD_LEN;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (sts.more_groups)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_GROUP;
                end
                else
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_GROUP:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = LD_GRP;
                    state_next = ST_READ;
                end
            end
            ST_CLOSE:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = LD_CLOSE;
                    cmd.last   = !end_reg;
                    state_next = end_reg ? ST_TERM : ST_IDLE;
                end
            end
            ST_TERM:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = LD_TERM;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/uule_datapath.sv]
// Line buffer, counters, sequence character and output register of the encoder.
module uule_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [7:0]                        data_byte,
    input  uule_pkg::cmd_t                    cmd,
    input  logic                              m_tready,
    output uule_pkg::status_t                 sts,
    output logic                              m_tvalid,
    output logic [uule_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import uule_pkg::*;

    // Each entry holds one complete three-byte group, first byte on top.
    logic [23:0]          mem [LINE_GROUPS];

    logic [CNT_W-1:0]     byte_cnt_reg;
    logic [CNT_W-1:0]     byte_cnt_next;
    logic [GRP_CNT_W-1:0] grp_cnt_reg;
    logic [GRP_CNT_W-1:0] grp_cnt_next;
    logic [1:0]           lane_reg;
    logic [1:0]           lane_next;
    logic [CHAR_W-1:0]    seq_reg;
    logic [CHAR_W-1:0]    seq_next;
    logic [GRP_CNT_W-1:0] rd_idx_reg;
    logic [GRP_CNT_W-1:0] rd_idx_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic [23:0]          hold_reg;
    logic [23:0]          rd_data_reg;
    logic                 use_hold_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                 out_line_end_reg;
    logic                 out_last_reg;

    logic [GRP_CNT_W-1:0] grp_total;
    logic [23:0]          grp_word;
    logic [7:0]           byte_a;
    logic [7:0]           byte_b;
    logic [7:0]           byte_c;
    logic [CHAR_W-1:0]    c0;
    logic [CHAR_W-1:0]    c1;
    logic [CHAR_W-1:0]    c2;
    logic [CHAR_W-1:0]    c3;
    logic [2:0]           cnt;
    logic                 line_end;
    logic                 do_load;
    logic                 rd_from_mem;

    assign grp_total   = grp_cnt_reg + GRP_CNT_W'(lane_reg != 2'd0);
    assign rd_from_mem = rd_idx_reg < grp_cnt_reg;
    assign do_load     = cmd.load != LD_NONE;

    assign sts.buf_empty   = byte_cnt_reg == '0;
    assign sts.fills_line  = byte_cnt_reg == CNT_W'(LINE_BYTES - 1);
    assign sts.more_groups = rd_idx_reg < grp_total;
    assign sts.out_free    = !out_valid_reg || m_tready;

    always_comb
    begin
        byte_cnt_next  = byte_cnt_reg;
        grp_cnt_next   = grp_cnt_reg;
        lane_next      = lane_reg;
        seq_next       = seq_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (do_load)
        begin
            out_valid_next = 1'b1;
        end
        if (cmd.store)
        begin
            byte_cnt_next = byte_cnt_reg + CNT_W'(1);
            if (lane_reg == 2'd2)
            begin
                lane_next    = 2'd0;
                grp_cnt_next = grp_cnt_reg + GRP_CNT_W'(1);
            end
            else
            begin
                lane_next = lane_reg + 2'd1;
            end
        end
        if (cmd.rd_issue)
        begin
            rd_idx_next = rd_idx_reg + GRP_CNT_W'(1);
        end
        if (cmd.load == LD_CLOSE)
        begin
            byte_cnt_next = '0;
            grp_cnt_next  = '0;
            lane_next     = 2'd0;
            rd_idx_next   = '0;
            seq_next      = next_seq(seq_reg);
        end
        if (cmd.load == LD_TERM)
        begin
            seq_next = next_seq(seq_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg  <= '0;
            grp_cnt_reg   <= '0;
            lane_reg      <= 2'd0;
            seq_reg       <= SEQ_HIGH;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            byte_cnt_reg  <= byte_cnt_next;
            grp_cnt_reg   <= grp_cnt_next;
            lane_reg      <= lane_next;
            seq_reg       <= seq_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A partial group builds up here; the lanes not yet written stay zero.
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            case (lane_reg)
                2'd0:    hold_reg <= {data_byte, 16'd0};
                2'd1:    hold_reg[15:8] <= data_byte;
                default: hold_reg <= hold_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store && lane_reg == 2'd2)
        begin
            mem[grp_cnt_reg[GRP_IDX_W-1:0]] <= {hold_reg[23:8], data_byte};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            use_hold_reg <= !rd_from_mem;
            if (rd_from_mem)
            begin
                rd_data_reg <= mem[rd_idx_reg[GRP_IDX_W-1:0]];
            end
        end
    end

    assign grp_word = use_hold_reg ? hold_reg : rd_data_reg;
    assign byte_a   = grp_word[23:16];
    assign byte_b   = grp_word[15:8];
    assign byte_c   = grp_word[7:0];

    always_comb
    begin
        c0       = CHAR_NONE;
        c1       = CHAR_NONE;
        c2       = CHAR_NONE;
        c3       = CHAR_NONE;
        cnt      = COUNT_LEN;
        line_end = 1'b0;
        case (cmd.load)
            LD_LEN:
            begin
                c0  = enc6(6'(byte_cnt_reg));
                cnt = COUNT_LEN;
            end
            LD_GRP:
            begin
                c0  = enc6(byte_a[7:2]);
                c1  = enc6({byte_a[1:0], byte_b[7:4]});
                c2  = enc6({byte_b[3:0], byte_c[7:6]});
                c3  = enc6(byte_c[5:0]);
                cnt = COUNT_GROUP;
            end
            LD_CLOSE:
            begin
                c0       = seq_reg;
                c1       = CHAR_NL;
                cnt      = COUNT_CLOSE;
                line_end = 1'b1;
            end
            LD_TERM:
            begin
                c0       = CHAR_SPACE;
                c1       = seq_reg;
                c2       = CHAR_NL;
                cnt      = COUNT_TERM;
                line_end = 1'b1;
            end
            default:
            begin
                cnt = COUNT_LEN;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            out_data_reg     <= {1'b0, cnt, c3, c2, c1, c0};
            out_line_end_reg <= line_end;
            out_last_reg     <= cmd.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_line_end_reg;
    assign m_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_cnt_reg <= CNT_W'(LINE_BYTES))
        else $error("byte count beyond line length");

    a_count_split: assert property (@(posedge clk) disable iff (!rst_n)
        byte_cnt_reg == CNT_W'(grp_cnt_reg * 3 + lane_reg))
        else $error("byte count disagrees with group count and lane");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        do_load |-> sts.out_free)
        else $error("chunk loaded over an unaccepted beat");

    a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg >= SEQ_LOW && seq_reg <= SEQ_HIGH)
        else $error("sequence character out of range");

    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |=> rd_idx_reg <= grp_total)
        else $error("group read past end of line");

endmodule

[rtl/core/uuencode_line_encoder_unit.sv]
// Top level of the uuencode line encoder: controller plus datapath.
//
// Raw bytes arrive on the s_ channel, one per beat. s_tuser is the mode: 0 carries
// a data byte in s_tdata, 1 marks end of input (s_tdata ignored). Bytes collect
// into a 45-byte line. When the 45th byte arrives, or at end of input with bytes
// pending, the line leaves on the m_ channel as chunks of one to four characters:
// the length character, one four-character chunk per three bytes, then the
// sequence character with newline. End of input also sends the terminator chunk
// (space, sequence character, newline). m_tlast marks the final chunk caused by
// one input beat; m_tuser marks chunks that end with a newline.
// The beat that causes a line moves the controller to ST_LEN, which loads the
// length chunk into the output register once it is free. Bytes that do not
// complete a line are accepted back to back. A line takes the length chunk, then
// per group a registered buffer read and an output load, then a step to find no
// group left and the closing chunk, plus the terminator after an end. Input
// is refused until the last chunk of the line is loaded. A stalled receiver
// makes the output register hold its beat and the controller wait; nothing is
// lost or repeated. Reset empties the buffer and sets the sequence to 'z'.
module uuencode_line_encoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [6:0] char0, [13:7] char1, [20:14] char2,
                                   // [27:21] char3, [30:28] char_count, [31] zero
    output logic        m_tuser,   // [0] line_end
    output logic        m_tlast    // last
);
    import uule_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // The controller sequences the chunks of a line.
    uule_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .mode     (s_tuser),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // The datapath holds the line buffer and builds each output beat.
    uule_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (s_tdata),
        .cmd       (cmd),
        .m_tready  (m_tready),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[verif/uuencode_line_encoder_unit_test.sv]
// Self-checking testbench for the uuencode line encoder, with a behavioral predictor.
`timescale 1ns / 1ps

module uuencode_line_encoder_unit_test;

    import uule_pkg::*;

    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_END  = 1'b1;
    localparam int   BEAT_GOAL = 120;   // directed plus random input beats

    // Back-pressure phases: receiver slow, then sender slow, then free running.
    typedef enum int {
        PH_RX_SLOW,
        PH_TX_SLOW,
        PH_FREE
    } phase_t;

    typedef struct {
        logic       mode;
        logic [7:0] data;
        phase_t     phase;
        bit         drain;   // hold this beat back until every chunk has arrived
    } src_beat_t;

    typedef struct {
        logic [CHAR_W-1:0] c0;
        logic [CHAR_W-1:0] c1;
        logic [CHAR_W-1:0] c2;
        logic [CHAR_W-1:0] c3;
        logic [2:0]        cnt;
        logic              line_end;
        logic              last;
    } chunk_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_tuser  = 1'b0;    // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [6:0] char0, [13:7] char1, [20:14] char2,
                                     // [27:21] char3, [30:28] char_count, [31] zero
    logic        m_tuser;            // [0] line_end
    logic        m_tlast;

    uuencode_line_encoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stimulus and expectation queues.
    src_beat_t tx_beats [$];
    chunk_t    chunk_q [$];

    // Predictor state: the bytes of the line being collected and the
    // sequence character that the next line or terminator will carry.
    logic [7:0]        line_buf [LINE_BYTES];
    int                line_fill = 0;
    logic [CHAR_W-1:0] seq_ch    = SEQ_HIGH;

    int tx_gap_pct [3] = '{8, 67, 0};
    int rx_gap_pct [3] = '{67, 8, 0};

    phase_t    fill_phase = PH_RX_SLOW;
    phase_t    prev_phase = PH_RX_SLOW;
    phase_t    cur_phase  = PH_RX_SLOW;
    src_beat_t next_beat;
    bit        stim_go    = 1'b0;
    bit        in_taken   = 1'b0;

    int mismatches = 0;
    int n_in       = 0;
    int n_end      = 0;
    int n_chunks   = 0;
    int n_lines    = 0;
    int n_wraps    = 0;
    int n_drains   = 0;

    function automatic logic [CHAR_W-1:0] to_char(input logic [5:0] v);
        return 7'(v) + CHAR_SPACE;
    endfunction

    task automatic push_chunk(input logic [CHAR_W-1:0] c0, input logic [CHAR_W-1:0] c1,
                              input logic [CHAR_W-1:0] c2, input logic [CHAR_W-1:0] c3,
                              input logic [2:0] cnt, input logic line_end);
        chunk_t ck;
        ck.c0       = c0;
        ck.c1       = c1;
        ck.c2       = c2;
        ck.c3       = c3;
        ck.cnt      = cnt;
        ck.line_end = line_end;
        ck.last     = 1'b0;
        chunk_q.push_back(ck);
    endtask

    // Sequence character steps down one per line or terminator, 'a' wraps to 'z'.
    task automatic step_seq();
        if (seq_ch == SEQ_LOW)
        begin
            seq_ch = SEQ_HIGH;
            n_wraps++;
        end
        else
        begin
            seq_ch = seq_ch - 7'd1;
        end
    endtask

    task automatic emit_line();
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        push_chunk(to_char(6'(line_fill)), CHAR_NONE, CHAR_NONE, CHAR_NONE, COUNT_LEN, 1'b0);
        for (int i = 0; i < line_fill; i += 3)
        begin
            // Bytes missing from the last group of a short line count as zero.
            a = line_buf[i];
            b = (i + 1 < line_fill) ? line_buf[i + 1] : 8'h00;
            c = (i + 2 < line_fill) ? line_buf[i + 2] : 8'h00;
            push_chunk(to_char(a[7:2]), to_char({a[1:0], b[7:4]}),
                       to_char({b[3:0], c[7:6]}), to_char(c[5:0]), COUNT_GROUP, 1'b0);
        end
        push_chunk(seq_ch, CHAR_NL, CHAR_NONE, CHAR_NONE, COUNT_CLOSE, 1'b1);
        step_seq();
        line_fill = 0;
        n_lines++;
    endtask

    // Works out the chunks that one accepted input beat produces.
    task automatic encode_beat(input logic mode, input logic [7:0] data);
        int n0;
        n0 = chunk_q.size();
        if (mode == MODE_DATA)
        begin
            line_buf[line_fill] = data;
            line_fill++;
            if (line_fill == LINE_BYTES)
            begin
                emit_line();
            end
        end
        else
        begin
            if (line_fill != 0)
            begin
                emit_line();
            end
            push_chunk(CHAR_SPACE, seq_ch, CHAR_NL, CHAR_NONE, COUNT_TERM, 1'b1);
            step_seq();
            n_end++;
        end
        if (chunk_q.size() > n0)
        begin
            chunk_q[chunk_q.size() - 1].last = 1'b1;
        end
    endtask

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("chunk %0d field %s: expected %0d, got %0d", n_chunks, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_chunk();
        chunk_t want;
        if (chunk_q.size() == 0)
        begin
            $error("output beat with no chunk expected: tdata=%h tuser=%b tlast=%b",
                   m_tdata, m_tuser, m_tlast);
            mismatches++;
        end
        else
        begin
            want = chunk_q.pop_front();
            cmp_field("char0", want.c0, m_tdata[6:0]);
            cmp_field("char1", want.c1, m_tdata[13:7]);
            cmp_field("char2", want.c2, m_tdata[20:14]);
            cmp_field("char3", want.c3, m_tdata[27:21]);
            cmp_field("char_count", want.cnt, m_tdata[30:28]);
            cmp_field("tdata_pad", 0, m_tdata[31]);
            cmp_field("line_end", want.line_end, m_tuser);
            cmp_field("last", want.last, m_tlast);
        end
        n_chunks++;
    endtask

    // Monitor: both handshakes are sampled at the rising edge.
    always @(posedge clk)
    begin
        in_taken = s_tvalid && s_tready;
        if (in_taken)
        begin
            encode_beat(s_tuser, s_tdata);
            n_in++;
        end
        if (m_tvalid && m_tready)
        begin
            check_chunk();
        end
    end

    // Driver: inputs move on the falling edge, one beat held until accepted.
    always @(negedge clk)
    begin
        if (stim_go)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (tx_beats.size() != 0 && !(tx_beats[0].drain && chunk_q.size() != 0)
                    && $urandom_range(0, 99) >= tx_gap_pct[tx_beats[0].phase])
                begin
                    next_beat = tx_beats.pop_front();
                    cur_phase = next_beat.phase;
                    if (next_beat.drain)
                    begin
                        n_drains++;
                    end
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_beat.mode;
                    s_tdata  <= next_beat.data;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= rx_gap_pct[cur_phase]);
        end
    end

    task automatic push_beat(input logic mode, input logic [7:0] data);
        src_beat_t sb;
        int        ph;
        ph = (tx_beats.size() * 3) / BEAT_GOAL;
        fill_phase = phase_t'((ph > 2) ? 2 : ph);
        sb.mode  = mode;
        sb.data  = data;
        sb.phase = fill_phase;
        // Drain the pipeline at every phase change and now and then at random.
        sb.drain = (fill_phase != prev_phase) || ($urandom_range(0, 99) < 3);
        prev_phase = fill_phase;
        tx_beats.push_back(sb);
    endtask

    task automatic push_run(input int len, input bit with_end);
        for (int i = 0; i < len; i++)
        begin
            push_beat(MODE_DATA, 8'($urandom_range(0, 255)));
        end
        if (with_end)
        begin
            push_beat(MODE_END, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin : main_seq
        int r;

        // Directed: terminator alone (data ignored), short lines of one to four
        // bytes, some with padded last groups, extreme byte values, back-to-back ends.
        push_beat(MODE_END, 8'hFF);
        push_beat(MODE_DATA, 8'hFF);
        push_beat(MODE_END, 8'h00);
        push_beat(MODE_DATA, 8'h00);
        push_beat(MODE_DATA, 8'hFF);
        push_beat(MODE_END, 8'h5A);
        push_beat(MODE_DATA, 8'hFC);
        push_beat(MODE_DATA, 8'h0F);
        push_beat(MODE_DATA, 8'hC3);
        push_beat(MODE_END, 8'h00);
        push_beat(MODE_DATA, 8'hFF);
        push_beat(MODE_DATA, 8'hFF);
        push_beat(MODE_DATA, 8'hFF);
        push_beat(MODE_DATA, 8'h00);
        push_beat(MODE_END, 8'hA5);
        push_beat(MODE_DATA, 8'h00);
        push_beat(MODE_DATA, 8'h00);
        push_beat(MODE_DATA, 8'h00);
        push_beat(MODE_END, 8'hFF);
        push_beat(MODE_END, 8'h00);

        // Random: one exactly full line first (the end then finds an empty
        // buffer), then mostly short runs, some crossing a line boundary, and
        // some runs without an end so that bytes carry into the next run.
        push_run(LINE_BYTES, 1'b1);
        while (tx_beats.size() < BEAT_GOAL)
        begin
            r = $urandom_range(0, 99);
            if (r < 6 && tx_beats.size() + LINE_BYTES + 4 <= BEAT_GOAL)
            begin
                push_run($urandom_range(LINE_BYTES - 1, LINE_BYTES + 3),
                         $urandom_range(0, 99) < 85);
            end
            else
            begin
                push_run($urandom_range(0, 5), $urandom_range(0, 99) < 85);
            end
        end
        push_beat(MODE_END, 8'($urandom_range(0, 255)));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        stim_go = 1'b1;

        while (tx_beats.size() != 0 || s_tvalid || chunk_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        $display("Sent %0d input beats with %0d end markers; checked %0d chunks.",
                 n_in, n_end, n_chunks);
        $display("Encoded %0d lines, sequence wrapped %0d times, %0d drain pauses.",
                 n_lines, n_wraps, n_drains);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run under full back-pressure.
    initial
    begin
        #5_000_000;
        $display("Watchdog expired with %0d beats and %0d chunks still pending.",
                 tx_beats.size(), chunk_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
